[hw/rtl/mrk_pkg.sv]
package mrk_pkg;

  localparam int KEY_W = 64;
  localparam int VAL_W = 64;

  localparam logic [1:0] CMD_UPSERT = 2'd0;
  localparam logic [1:0] CMD_MARK   = 2'd1;
  localparam logic [1:0] CMD_SCAN   = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [KEY_W-1:0]  key;
    logic              key_valid;
    logic [VAL_W-1:0]  entry_value;
    logic              value_present;
    logic signed [7:0] signal_dbm;
    logic              scan_last;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       entry_count;
    logic             accepted;
    logic             select_done;
    logic             match_found;
    logic [KEY_W-1:0] picked_key;
    logic [VAL_W-1:0] picked_value;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

[hw/rtl/mrk_stream_if.sv]
interface mrk_stream_if #(
  parameter type T_t = logic
) ();
  logic valid;
  logic ready;
  T_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/mrk_ram.sv]
module mrk_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

[hw/rtl/mru_key_table_best_rssi_select_core.sv]
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    mrk_pkg::in_item_t (cmd, key, value, signal, scan_last)
// out_ch    out  valid/ready    mrk_pkg::out_item_t (count, flags, picked key/value)
//
// One item at a time; the single entry RAM port pair and one key comparator set the pace.
// An item is accepted, searched front to back if its key is valid, and on an upsert or
// a mark hit moved to the front; a last scan item adds a scan report; a result step ends
// each item. Reset (rst_n, synchronous) empties the table; no clearing pass.
// A stalled result holds in the output register while the next item is accepted.
module mru_key_table_best_rssi_select_core #(
  parameter int CAPACITY = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  mrk_stream_if.sink   in_ch,
  mrk_stream_if.source out_ch
);
  import mrk_pkg::*;

  localparam int OW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_SHIFT, S_WR0, S_REPORT, S_RPT_WAIT, S_RESP
  } state_t;

  state_t            state_r;
  in_item_t          itm_r;
  out_item_t         out_data_r;
  logic              out_valid_r;
  logic [OW-1:0]     occ_r;
  logic [OW-1:0]     ridx_r;
  logic              cmp_v_r;
  logic [AW-1:0]     cmp_idx_r;
  logic [AW-1:0]     sidx_r;
  logic [AW-1:0]     wr_idx_r;
  logic              pend_r;
  entry_t            ent_r;
  logic signed [7:0] best_sig_r;
  logic [AW-1:0]     best_pos_r;
  logic              best_seen_r;
  logic              res_acc_r;
  logic              res_done_r;
  logic              res_found_r;
  logic [KEY_W-1:0]  res_key_r;
  logic [VAL_W-1:0]  res_val_r;

  entry_t            rdata;
  entry_t            wr_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              hit;
  logic              miss;
  logic [OW-1:0]     occ_ins;
  logic              slot_free;

  mrk_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY)) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data_r(rdata)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign hit       = (state_r == S_SEARCH) && cmp_v_r && (rdata.key == itm_r.key);
  assign miss      = (state_r == S_SEARCH) && !hit && (ridx_r == occ_r);
  assign occ_ins   = (occ_r < OW'(CAPACITY)) ? OW'(occ_r + 1'b1) : occ_r;
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = ent_r;
    unique case (state_r)
      S_SEARCH: rd_addr = ridx_r[AW-1:0];
      S_SHIFT: begin
        rd_addr = AW'(sidx_r - 1'b1);
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = wr_idx_r;
          wr_data = rdata;
        end
      end
      S_WR0: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = ent_r;
      end
      S_REPORT: rd_addr = best_pos_r;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      occ_r       <= '0;
      best_sig_r  <= '0;
      best_pos_r  <= '0;
      best_seen_r <= 1'b0;
    end else begin
      if (state_r == S_RESP && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            itm_r       <= in_ch.data;
            ridx_r      <= '0;
            cmp_v_r     <= 1'b0;
            pend_r      <= 1'b0;
            res_acc_r   <= 1'b0;
            res_done_r  <= 1'b0;
            res_found_r <= 1'b0;
            res_key_r   <= '0;
            res_val_r   <= '0;
            if (in_ch.data.cmd != CMD_UPSERT && in_ch.data.cmd != CMD_MARK &&
                in_ch.data.cmd != CMD_SCAN) begin
              state_r <= S_RESP;
            end else if (!in_ch.data.key_valid) begin
              state_r <= (in_ch.data.cmd == CMD_SCAN && in_ch.data.scan_last) ?
                         S_REPORT : S_RESP;
            end else begin
              state_r <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (ridx_r < occ_r) begin
            cmp_v_r   <= 1'b1;
            cmp_idx_r <= ridx_r[AW-1:0];
            ridx_r    <= OW'(ridx_r + 1'b1);
          end else begin
            cmp_v_r <= 1'b0;
          end
          if (hit) begin
            unique case (itm_r.cmd)
              CMD_UPSERT: begin
                ent_r.key   <= itm_r.key;
                ent_r.value <= itm_r.value_present ? itm_r.entry_value : rdata.value;
                sidx_r      <= cmp_idx_r;
                res_acc_r   <= 1'b1;
                state_r     <= S_SHIFT;
              end
              CMD_MARK: begin
                ent_r     <= rdata;
                sidx_r    <= cmp_idx_r;
                res_acc_r <= 1'b1;
                state_r   <= S_SHIFT;
              end
              default: begin
                if (!best_seen_r || itm_r.signal_dbm > best_sig_r) begin
                  best_seen_r <= 1'b1;
                  best_sig_r  <= itm_r.signal_dbm;
                  best_pos_r  <= cmp_idx_r;
                end
                state_r <= itm_r.scan_last ? S_REPORT : S_RESP;
              end
            endcase
          end else if (miss) begin
            unique case (itm_r.cmd)
              CMD_UPSERT: begin
                occ_r       <= occ_ins;
                sidx_r      <= AW'(occ_ins - 1'b1);
                ent_r.key   <= itm_r.key;
                ent_r.value <= itm_r.value_present ? itm_r.entry_value : '0;
                res_acc_r   <= 1'b1;
                state_r     <= S_SHIFT;
              end
              CMD_MARK: state_r <= S_RESP;
              default:  state_r <= itm_r.scan_last ? S_REPORT : S_RESP;
            endcase
          end
        end
        S_SHIFT: begin
          if (sidx_r != '0) begin
            pend_r   <= 1'b1;
            wr_idx_r <= sidx_r;
            sidx_r   <= AW'(sidx_r - 1'b1);
          end else begin
            pend_r  <= 1'b0;
            state_r <= S_WR0;
          end
        end
        S_WR0: state_r <= S_RESP;
        S_REPORT: begin
          res_done_r  <= 1'b1;
          best_seen_r <= 1'b0;
          if (best_seen_r && (OW'(best_pos_r) < occ_r)) begin
            state_r <= S_RPT_WAIT;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_RPT_WAIT: begin
          res_found_r <= 1'b1;
          res_key_r   <= rdata.key;
          res_val_r   <= rdata.value;
          state_r     <= S_RESP;
        end
        S_RESP: begin
          if (slot_free) begin
            out_data_r.entry_count   <= 4'(occ_r);
            out_data_r.accepted      <= res_acc_r;
            out_data_r.select_done   <= res_done_r;
            out_data_r.match_found   <= res_found_r;
            out_data_r.picked_key    <= res_key_r;
            out_data_r.picked_value  <= res_val_r;
            state_r                  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(CAPACITY))
    else $error("occupancy above capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("transaction accepted while busy");

  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_SHIFT || state_r == S_WR0))
    else $error("table write outside move to front");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside response step");

  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && pend_r) |-> (OW'(wr_idx_r) < occ_r))
    else $error("shift writes past occupied entries");

endmodule
